// ----- hdl/msi_pkg.sv -----
// Package for the markup stream indenter: payload and command types, byte codes,
// depth limits and the indent length function. No dependencies.
`timescale 1ns / 1ps

package msi_pkg;

  localparam int unsigned MaxDepth     = 15;
  localparam int unsigned IndentSpaces = 4;
  localparam int unsigned DepthW       = 4;
  localparam int unsigned IndentW      = 6;
  localparam int unsigned CmdDepth     = 2;

  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChQuest = 8'h3F;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSp    = 8'h20;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } msi_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } msi_out_t;

  // One output run: optional line feed, indent spaces, optional '<', optional byte.
  typedef struct packed {
    logic               lead_lf;
    logic [IndentW-1:0] indent_len;
    logic               emit_lt;
    logic               emit_byte;
    logic [7:0]         run_byte;
  } msi_cmd_t;

  function automatic logic [IndentW-1:0] indent_of(input logic [DepthW-1:0] depth);
    logic [IndentW-1:0] len;
    len = IndentW'(depth) * IndentW'(IndentSpaces);
    return len;
  endfunction

endpackage

// ----- hdl/msi_front.sv -----
// Front end of the markup stream indenter: takes input transfers, tracks nesting
// state and turns each byte into at most one output run command. Depends on msi_pkg.
`timescale 1ns / 1ps

module msi_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  msi_pkg::msi_in_t   in_item_i,
  input  logic               cmd_full_i,
  output logic               cmd_push_o,
  output msi_pkg::msi_cmd_t  cmd_o
);

  logic [msi_pkg::DepthW-1:0] depth_q, depth_d;
  logic                       line_started_q, line_started_d;
  logic                       first_q, first_d;
  logic                       close_mark_q, close_mark_d;
  logic                       lt_pending_q, lt_pending_d;

  logic [msi_pkg::DepthW-1:0] depth_up, depth_dn;
  logic [7:0]                 c;
  logic                       is_space, is_mark, accept;
  msi_pkg::msi_cmd_t          cmd;

  assign c        = in_item_i.in_byte;
  assign accept   = push && !cmd_full_i;
  assign depth_up = (depth_q < msi_pkg::DepthW'(msi_pkg::MaxDepth)) ? depth_q + 1'b1 : depth_q;
  assign depth_dn = (depth_q != '0) ? depth_q - 1'b1 : depth_q;
  assign is_space = (c == msi_pkg::ChSp) || (c >= msi_pkg::ChTab && c <= msi_pkg::ChCr);
  assign is_mark  = (c == msi_pkg::ChSlash) || (c == msi_pkg::ChQuest);

  always_comb begin
    depth_d        = depth_q;
    line_started_d = line_started_q;
    first_d        = first_q;
    close_mark_d   = close_mark_q;
    lt_pending_d   = lt_pending_q;
    cmd            = '0;
    cmd.run_byte   = c;
    if (in_item_i.end_of_stream) begin
      if (lt_pending_q) begin
        cmd.indent_len = msi_pkg::indent_of(depth_q);
        cmd.emit_lt    = 1'b1;
      end else if (!line_started_q) begin
        cmd.lead_lf = 1'b1;
      end
      depth_d        = '0;
      line_started_d = 1'b1;
      first_d        = 1'b1;
      close_mark_d   = 1'b0;
      lt_pending_d   = 1'b0;
    end else if (lt_pending_q) begin
      if (c != msi_pkg::ChSlash) begin
        cmd.indent_len = msi_pkg::indent_of(depth_q);
        depth_d        = depth_up;
      end else begin
        cmd.indent_len = msi_pkg::indent_of(depth_dn);
        depth_d        = depth_dn;
      end
      cmd.emit_lt    = 1'b1;
      cmd.emit_byte  = (c != msi_pkg::ChLf);
      line_started_d = 1'b1;
      lt_pending_d   = 1'b0;
      close_mark_d   = is_mark;
      first_d        = 1'b0;
    end else if (c == msi_pkg::ChLt) begin
      cmd.lead_lf  = !first_q;
      lt_pending_d = 1'b1;
      close_mark_d = 1'b0;
      first_d      = 1'b0;
    end else if (c == msi_pkg::ChGt) begin
      cmd.emit_byte = 1'b1;
      if (close_mark_q) begin
        depth_d = depth_dn;
      end
      line_started_d = 1'b0;
      close_mark_d   = 1'b0;
      first_d        = 1'b0;
    end else begin
      if (c != msi_pkg::ChLf && c != msi_pkg::ChCr) begin
        if (!is_space) begin
          if (!line_started_q) begin
            cmd.lead_lf    = 1'b1;
            cmd.indent_len = msi_pkg::indent_of(depth_q);
          end
          line_started_d = 1'b1;
        end
        cmd.emit_byte = 1'b1;
      end
      close_mark_d = is_mark;
      first_d      = 1'b0;
    end
  end

  assign cmd_o      = cmd;
  assign cmd_push_o = accept &&
                      (cmd.lead_lf || cmd.indent_len != '0 || cmd.emit_lt || cmd.emit_byte);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q        <= '0;
      line_started_q <= 1'b1;
      first_q        <= 1'b1;
      close_mark_q   <= 1'b0;
      lt_pending_q   <= 1'b0;
    end else if (accept) begin
      depth_q        <= depth_d;
      line_started_q <= line_started_d;
      first_q        <= first_d;
      close_mark_q   <= close_mark_d;
      lt_pending_q   <= lt_pending_d;
    end
  end

endmodule

// ----- hdl/msi_cmd_fifo.sv -----
// Short command queue between the front end and the output sequencer of the
// markup stream indenter. Depends on msi_pkg.
`timescale 1ns / 1ps

module msi_cmd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  msi_pkg::msi_cmd_t wr_data_i,
  input  logic              rd_en_i,
  output msi_pkg::msi_cmd_t rd_data_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int unsigned PtrW = (msi_pkg::CmdDepth > 1) ? $clog2(msi_pkg::CmdDepth) : 1;
  localparam int unsigned CntW = $clog2(msi_pkg::CmdDepth + 1);

  msi_pkg::msi_cmd_t mem_q [msi_pkg::CmdDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_wr, do_rd;

  assign full_o    = (count_q == CntW'(msi_pkg::CmdDepth));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(msi_pkg::CmdDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(msi_pkg::CmdDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/msi_back.sv -----
// Output sequencer of the markup stream indenter: expands run commands into
// single bytes behind an output register. Depends on msi_pkg.
`timescale 1ns / 1ps

module msi_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_empty_i,
  input  msi_pkg::msi_cmd_t   cmd_i,
  output logic                cmd_pop_o,
  input  logic                pop,
  output logic                empty,
  output msi_pkg::msi_out_t   out_item_o
);

  logic                        busy_q, busy_d;
  logic                        lf_q, lf_d;
  logic [msi_pkg::IndentW-1:0] cnt_q, cnt_d;
  logic                        lt_q, lt_d;
  logic                        bv_q, bv_d;
  logic [7:0]                  byte_q, byte_d;
  logic                        out_vld_q, out_vld_d;
  msi_pkg::msi_out_t           out_q, out_d;
  logic                        slot_free, last;
  logic [7:0]                  nxt;

  assign slot_free = !out_vld_q || pop;

  always_comb begin
    busy_d    = busy_q;
    lf_d      = lf_q;
    cnt_d     = cnt_q;
    lt_d      = lt_q;
    bv_d      = bv_q;
    byte_d    = byte_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    cmd_pop_o = 1'b0;
    nxt       = byte_q;
    last      = 1'b0;
    if (busy_q && slot_free) begin
      if (lf_q) begin
        nxt  = msi_pkg::ChLf;
        lf_d = 1'b0;
      end else if (cnt_q != '0) begin
        nxt   = msi_pkg::ChSp;
        cnt_d = cnt_q - 1'b1;
      end else if (lt_q) begin
        nxt  = msi_pkg::ChLt;
        lt_d = 1'b0;
      end else begin
        nxt  = byte_q;
        bv_d = 1'b0;
      end
      last              = !(lf_d || cnt_d != '0 || lt_d || bv_d);
      busy_d            = !last;
      out_vld_d         = 1'b1;
      out_d.out_byte    = nxt;
      out_d.last_of_run = last;
    end else begin
      if (slot_free) begin
        out_vld_d = 1'b0;
      end
      if (!busy_q && !cmd_empty_i) begin
        cmd_pop_o = 1'b1;
        busy_d    = 1'b1;
        lf_d      = cmd_i.lead_lf;
        cnt_d     = cmd_i.indent_len;
        lt_d      = cmd_i.emit_lt;
        bv_d      = cmd_i.emit_byte;
        byte_d    = cmd_i.run_byte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lf_q   <= lf_d;
    cnt_q  <= cnt_d;
    lt_q   <= lt_d;
    bv_q   <= bv_d;
    byte_q <= byte_d;
    out_q  <= out_d;
  end

  assign empty      = !out_vld_q;
  assign out_item_o = out_q;

endmodule

// ----- hdl/markup_stream_indenter.sv -----
// Top level of the markup stream indenter: front end, command queue and output
// sequencer. Depends on msi_pkg, msi_front, msi_cmd_fifo and msi_back.
// A result byte passes the command queue, the run registers and the output register.
// Flow: the output sequencer loads a run command, then sends its bytes, and takes no new
// command until the run is sent; indent runs of up to 62 bytes hold the queue full.
// Reset clears nesting state, the command queue and the output valid flag at once.
`timescale 1ns / 1ps

module markup_stream_indenter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  msi_pkg::msi_in_t  in_item_i,
  output logic              empty,
  input  logic              pop,
  output msi_pkg::msi_out_t out_item_o
);

  msi_pkg::msi_cmd_t wr_cmd, rd_cmd;
  logic              cmd_push, cmd_pop, cmd_full, cmd_empty;

  assign full = cmd_full;

  msi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_item_i  (in_item_i),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (wr_cmd)
  );

  msi_cmd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cmd_push),
    .wr_data_i (wr_cmd),
    .rd_en_i   (cmd_pop),
    .rd_data_o (rd_cmd),
    .full_o    (cmd_full),
    .empty_o   (cmd_empty)
  );

  msi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (rd_cmd),
    .cmd_pop_o   (cmd_pop),
    .pop         (pop),
    .empty       (empty),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- hdl/msi_checker.sv -----
// Port-level checks for the markup stream indenter, attached by bind.
// Depends on msi_pkg and markup_stream_indenter.
`timescale 1ns / 1ps

module msi_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input msi_pkg::msi_out_t out_item_o
);

  assert property (@(posedge clk_i) !rst_ni |-> (empty && !full))
    else $error("Queue flags not cleared during reset.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("Waiting result changed or vanished before its transfer.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_item_o.last_of_run) |->
      (out_item_o.out_byte == msi_pkg::ChLf || out_item_o.out_byte == msi_pkg::ChSp ||
       out_item_o.out_byte == msi_pkg::ChLt))
    else $error("Only line feed, indent space or '<' may precede the end of a run.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.out_byte == msi_pkg::ChGt && !$past(empty) &&
     $past(out_item_o.out_byte) == msi_pkg::ChLt && !$past(pop)) |-> 1'b0)
    else $error("Waiting '<' was replaced without a transfer.");

endmodule

bind markup_stream_indenter msi_checker u_msi_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);
